/* rtl/core/cts_pkg.sv */
// -----------------------------------------------------------------------------
// Cosine series package
// Shared widths, register indexes, the division-chain lane type and the
// per-term divisor function for the cosine Maclaurin series block.
// -----------------------------------------------------------------------------
package cts_pkg;

	localparam int MAX_TERMS = 32;
	localparam int FRAC_W    = 50;
	localparam int ANGLE_W   = 54;
	localparam int COS_W     = 58;
	localparam int REM_W     = 57;
	localparam int TOL_W     = 51;
	localparam int CNT_W     = 6;
	localparam int TERMS_W   = 6;

	// Term index counter and the divisor (2k)(2k-1) that it selects.
	localparam int K_W   = $clog2(MAX_TERMS + 1);
	localparam int DIV_W = 2 * (K_W + 1);

	// Term magnitudes saturate at 2^62-1; the running sum lives in [-2^62, 2^62].
	localparam int TERM_W = 62;
	localparam int SUM_W  = TERM_W + 2;

	// Multiplier operand split into two partial words per operand.
	localparam int A_LO_W = TERM_W / 2;
	localparam int B_LO_W = ANGLE_W / 2;
	localparam int A_PW   = TERM_W - A_LO_W;
	localparam int B_PW   = ANGLE_W - B_LO_W;
	localparam int PP_W   = A_PW + B_PW;
	localparam int PROD_W = TERM_W + ANGLE_W;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CNT = 1'b1;

	// Request kinds.
	localparam logic KIND_TOL   = 1'b0;
	localparam logic KIND_FIXED = 1'b1;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(11258999);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(8);

	typedef struct packed {
		logic              v;
		logic [DIV_W-1:0]  rem;
		logic [TERM_W-1:0] word;
		logic [DIV_W-1:0]  den;
	} div_lane_t;

	function automatic logic [DIV_W-1:0] term_divisor(input logic [K_W-1:0] k);
		logic [K_W:0] two_k;
		logic [K_W:0] two_k_m1;
		two_k    = {k, 1'b0};
		two_k_m1 = two_k - 1'b1;
		return DIV_W'(two_k) * DIV_W'(two_k_m1);
	endfunction

endpackage

/* rtl/core/cosine_taylor_series.sv */
// -----------------------------------------------------------------------------
// Cosine Maclaurin series
// Sums cos x term by term in 2^-50 fixed point, in tolerance or fixed mode.
// -----------------------------------------------------------------------------
// One request at a time: busy stays high from the accepting edge until the
// done strobe; each term takes two multiplies in turn, then the 62-cell division chain.
// Reset clears the sequencer, the strobe and restores both registers.
// The receiver cannot stall: done is high for exactly one cycle per request.
// -----------------------------------------------------------------------------
module cosine_taylor_series (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic signed [cts_pkg::ANGLE_W-1:0] angle,
	output logic                              done,
	output logic signed [cts_pkg::COS_W-1:0]  cosine,
	output logic [cts_pkg::REM_W-1:0]         remainder,
	output logic [cts_pkg::TERMS_W-1:0]       terms_used,
	output logic                              capped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cts_pkg::TOL_W-1:0]         cfg_data
);

	// Sequencer states. LOAD launches the first multiply once the absolute
	// angle has been captured; M1 and M2 wait on the two multiplies of a term
	// and DV waits on the division chain, where the term is judged.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_M1   = 3'd2;
	localparam logic [2:0] ST_M2   = 3'd3;
	localparam logic [2:0] ST_DV   = 3'd4;

	localparam logic [cts_pkg::TERM_W-1:0] ONE_TERM =
		{{(cts_pkg::TERM_W-cts_pkg::FRAC_W-1){1'b0}}, 1'b1, {cts_pkg::FRAC_W{1'b0}}};
	localparam logic signed [cts_pkg::SUM_W-1:0] SUM_HI =
		{2'b01, {cts_pkg::TERM_W{1'b0}}};
	localparam logic signed [cts_pkg::SUM_W-1:0] SUM_LO =
		{2'b11, {cts_pkg::TERM_W{1'b0}}};
	localparam logic signed [cts_pkg::SUM_W-1:0] COS_HI =
		{{(cts_pkg::SUM_W-cts_pkg::COS_W+1){1'b0}}, {(cts_pkg::COS_W-1){1'b1}}};
	localparam logic signed [cts_pkg::SUM_W-1:0] COS_LO =
		{{(cts_pkg::SUM_W-cts_pkg::COS_W+1){1'b1}}, {(cts_pkg::COS_W-1){1'b0}}};
	localparam logic [cts_pkg::K_W-1:0] K_MAX = cts_pkg::K_W'(cts_pkg::MAX_TERMS);
	localparam logic [cts_pkg::K_W-1:0] K_ONE = cts_pkg::K_W'(1);

	// Configuration registers.
	logic [cts_pkg::TOL_W-1:0]    tol_q;
	logic [cts_pkg::CNT_W-1:0]    cnt_q;

	// Per-request state.
	logic [2:0]                   state_q;
	logic                         kind_q;
	logic [cts_pkg::ANGLE_W-1:0]  ax_q;
	logic [cts_pkg::K_W-1:0]      n_q;
	logic [cts_pkg::K_W-1:0]      k_q;
	logic signed [cts_pkg::SUM_W-1:0] sum_q;

	// Result registers.
	logic                         done_q;
	logic [cts_pkg::COS_W-1:0]    cosine_q;
	logic [cts_pkg::REM_W-1:0]    rem_q;
	logic [cts_pkg::TERMS_W-1:0]  terms_q;
	logic                         capped_q;

	logic                         accept;
	logic [cts_pkg::ANGLE_W-1:0]  angle_u;
	logic [cts_pkg::ANGLE_W-1:0]  ax_d;
	logic [cts_pkg::K_W-1:0]      n_d;

	logic                         mul_go;
	logic [cts_pkg::TERM_W-1:0]   mul_a;
	logic                         mul_done;
	logic [cts_pkg::TERM_W-1:0]   mul_res;
	logic                         div_go;
	logic                         div_done;
	logic [cts_pkg::TERM_W-1:0]   nm;

	logic                         below;
	logic                         at_limit;
	logic                         last;
	logic                         cap_hit;
	logic signed [cts_pkg::SUM_W-1:0] nm_s;
	logic signed [cts_pkg::SUM_W-1:0] sum_raw;
	logic signed [cts_pkg::SUM_W-1:0] sum_sat;
	logic signed [cts_pkg::SUM_W-1:0] cos_sat;
	logic [cts_pkg::REM_W-1:0]    rem_sat;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Absolute angle. The most negative angle maps onto 2^53, which still
	// fits the unsigned field.
	assign angle_u = angle;
	assign ax_d    = angle_u[cts_pkg::ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;

	// Fixed mode treats a count of zero as one and clips anything above the
	// term limit.
	always_comb begin
		if (cnt_q == '0) begin
			n_d = K_ONE;
		end else if (cnt_q > cts_pkg::CNT_W'(cts_pkg::MAX_TERMS)) begin
			n_d = K_MAX;
		end else begin
			n_d = cts_pkg::K_W'(cnt_q);
		end
	end

	// Judging the term that has just left the division chain. Odd terms are
	// negative. Tolerance mode always keeps the first term and tests from the
	// second onwards; it gives up at the term limit and raises capped.
	assign below    = nm < cts_pkg::TERM_W'(tol_q);
	assign at_limit = k_q >= K_MAX;

	always_comb begin
		if (kind_q == cts_pkg::KIND_TOL) begin
			last    = (k_q != K_ONE) && (below || at_limit);
			cap_hit = (k_q != K_ONE) && !below && at_limit;
		end else begin
			last    = k_q >= n_q;
			cap_hit = 1'b0;
		end
	end

	// Running sum, held within [-2^62, 2^62].
	assign nm_s    = cts_pkg::SUM_W'(nm);
	assign sum_raw = k_q[0] ? (sum_q - nm_s) : (sum_q + nm_s);

	always_comb begin
		if (sum_raw > SUM_HI) begin
			sum_sat = SUM_HI;
		end else if (sum_raw < SUM_LO) begin
			sum_sat = SUM_LO;
		end else begin
			sum_sat = sum_raw;
		end
	end

	// Output clamps for the reported cosine and remainder.
	always_comb begin
		if (sum_q > COS_HI) begin
			cos_sat = COS_HI;
		end else if (sum_q < COS_LO) begin
			cos_sat = COS_LO;
		end else begin
			cos_sat = sum_q;
		end
	end

	assign rem_sat = (|nm[cts_pkg::TERM_W-1:cts_pkg::REM_W]) ? {cts_pkg::REM_W{1'b1}}
	                                                          : nm[cts_pkg::REM_W-1:0];

	// Operand selection for the shared multiplier: the first request of a
	// term takes the previous magnitude, the second takes the first product.
	always_comb begin
		mul_go = 1'b0;
		mul_a  = nm;
		unique case (state_q)
			ST_LOAD: begin
				mul_go = 1'b1;
				mul_a  = ONE_TERM;
			end
			ST_M1: begin
				mul_go = mul_done;
				mul_a  = mul_res;
			end
			ST_DV: begin
				mul_go = div_done && !last;
				mul_a  = nm;
			end
			default: begin
				mul_go = 1'b0;
				mul_a  = nm;
			end
		endcase
	end

	assign div_go = (state_q == ST_M2) && mul_done;

	cts_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (ax_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	cts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (mul_res),
		.den    (cts_pkg::term_divisor(k_q)),
		.done   (div_done),
		.quo    (nm)
	);

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			tol_q   <= cts_pkg::TOL_RESET;
			cnt_q   <= cts_pkg::CNT_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					cts_pkg::CFG_TOL: tol_q <= cfg_data;
					cts_pkg::CFG_CNT: cnt_q <= cfg_data[cts_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_M1;
				end
				ST_M1: begin
					if (mul_done) begin
						state_q <= ST_M2;
					end
				end
				ST_M2: begin
					if (mul_done) begin
						state_q <= ST_DV;
					end
				end
				ST_DV: begin
					if (div_done) begin
						if (last) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_M1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload, running sum and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			ax_q   <= ax_d;
			n_q    <= n_d;
			k_q    <= K_ONE;
			sum_q  <= cts_pkg::SUM_W'(ONE_TERM);
		end else if ((state_q == ST_DV) && div_done) begin
			if (last) begin
				cosine_q <= cos_sat[cts_pkg::COS_W-1:0];
				rem_q    <= rem_sat;
				terms_q  <= cts_pkg::TERMS_W'(k_q);
				capped_q <= cap_hit;
			end else begin
				sum_q <= sum_sat;
				k_q   <= k_q + 1'b1;
			end
		end
	end

	assign done       = done_q;
	assign cosine     = cosine_q;
	assign remainder  = rem_q;
	assign terms_used = terms_q;
	assign capped     = capped_q;

endmodule

/* rtl/core/cts_mul.sv */
// -----------------------------------------------------------------------------
// Cosine series multiplier
// Sequential 62 x 54 multiplier built from four partial products, giving
// floor(a * b / 2^50) saturated at 2^62-1.
// -----------------------------------------------------------------------------
module cts_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [cts_pkg::TERM_W-1:0]   a,
	input  logic [cts_pkg::ANGLE_W-1:0]  b,
	output logic                         done,
	output logic [cts_pkg::TERM_W-1:0]   res
);

	localparam logic [2:0] STEP_ISSUE_END = 3'd4;
	localparam logic [2:0] STEP_SAT       = 3'd5;

	logic                          run_q;
	logic [2:0]                    step_q;
	logic                          pv_s1;
	logic [1:0]                    sel_s1;
	logic [cts_pkg::PP_W-1:0]      pp_s1;
	logic [cts_pkg::TERM_W-1:0]    a_q;
	logic [cts_pkg::PROD_W-1:0]    acc_q;
	logic                          done_q;
	logic [cts_pkg::TERM_W-1:0]    res_q;

	logic [cts_pkg::A_PW-1:0]      a_part;
	logic [cts_pkg::B_PW-1:0]      b_part;
	logic [cts_pkg::PP_W-1:0]      pp_d;
	logic [cts_pkg::PROD_W-1:0]    pp_ext;
	logic [cts_pkg::PROD_W-1:0]    pp_sh;
	logic                          issue;
	logic [cts_pkg::TERM_W-1:0]    sat_d;

	assign issue  = run_q && (step_q < STEP_ISSUE_END);
	assign a_part = step_q[0] ? cts_pkg::A_PW'(a_q >> cts_pkg::A_LO_W)
	                          : cts_pkg::A_PW'(a_q[cts_pkg::A_LO_W-1:0]);
	assign b_part = step_q[1] ? cts_pkg::B_PW'(b >> cts_pkg::B_LO_W)
	                          : cts_pkg::B_PW'(b[cts_pkg::B_LO_W-1:0]);
	assign pp_d   = cts_pkg::PP_W'(a_part) * cts_pkg::PP_W'(b_part);
	assign pp_ext = cts_pkg::PROD_W'(pp_s1);

	always_comb begin
		case (sel_s1)
			2'd0:    pp_sh = pp_ext;
			2'd1:    pp_sh = pp_ext << cts_pkg::A_LO_W;
			2'd2:    pp_sh = pp_ext << cts_pkg::B_LO_W;
			default: pp_sh = pp_ext << (cts_pkg::A_LO_W + cts_pkg::B_LO_W);
		endcase
	end

	// Anything at or above 2^(50+62) in the product saturates the term.
	assign sat_d = (|acc_q[cts_pkg::PROD_W-1:cts_pkg::FRAC_W+cts_pkg::TERM_W])
	             ? {cts_pkg::TERM_W{1'b1}}
	             : acc_q[cts_pkg::FRAC_W+cts_pkg::TERM_W-1:cts_pkg::FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pv_s1  <= issue;
			done_q <= run_q && (step_q == STEP_SAT);
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_SAT) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
		end
		if (issue) begin
			pp_s1  <= pp_d;
			sel_s1 <= step_q[1:0];
		end
		if (go) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + pp_sh;
		end
		if (run_q && (step_q == STEP_SAT)) begin
			res_q <= sat_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/core/cts_cell.sv */
// -----------------------------------------------------------------------------
// Cosine series division cell
// One restoring division step: brings in the next dividend bit, subtracts the
// divisor where it fits and shifts the quotient bit in at the bottom.
// -----------------------------------------------------------------------------
module cts_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  cts_pkg::div_lane_t lane_i,
	output cts_pkg::div_lane_t lane_o
);

	logic [cts_pkg::DIV_W:0]    trial;
	logic [cts_pkg::DIV_W:0]    den_x;
	logic                       fits;
	logic [cts_pkg::DIV_W:0]    diff;
	logic                       v_q;
	logic [cts_pkg::DIV_W-1:0]  rem_q;
	logic [cts_pkg::TERM_W-1:0] word_q;
	logic [cts_pkg::DIV_W-1:0]  den_q;

	assign trial = {lane_i.rem, lane_i.word[cts_pkg::TERM_W-1]};
	assign den_x = {1'b0, lane_i.den};
	assign fits  = trial >= den_x;
	assign diff  = fits ? (trial - den_x) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= lane_i.v;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= diff[cts_pkg::DIV_W-1:0];
		word_q <= {lane_i.word[cts_pkg::TERM_W-2:0], fits};
		den_q  <= lane_i.den;
	end

	assign lane_o = {v_q, rem_q, word_q, den_q};

endmodule

/* rtl/core/cts_div.sv */
// -----------------------------------------------------------------------------
// Cosine series divider chain
// A row of division cells, one quotient bit each, dividing a term magnitude
// by the small divisor of the current term.
// -----------------------------------------------------------------------------
module cts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [cts_pkg::TERM_W-1:0]  num,
	input  logic [cts_pkg::DIV_W-1:0]   den,
	output logic                        done,
	output logic [cts_pkg::TERM_W-1:0]  quo
);

	cts_pkg::div_lane_t lane [0:cts_pkg::TERM_W];

	assign lane[0].v    = go;
	assign lane[0].rem  = '0;
	assign lane[0].word = num;
	assign lane[0].den  = den;

	for (genvar i = 0; i < cts_pkg::TERM_W; i++) begin : g_cell
		cts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lane_i (lane[i]),
			.lane_o (lane[i+1])
		);
	end

	assign done = lane[cts_pkg::TERM_W].v;
	assign quo  = lane[cts_pkg::TERM_W].word;

endmodule

/* rtl/core/cts_checker.sv */
// -----------------------------------------------------------------------------
// Cosine series port checker
// Watches the top-level ports for sequencing and result consistency.
// -----------------------------------------------------------------------------
module cts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [cts_pkg::TERMS_W-1:0]       terms_used,
	input logic                              capped
);

	// A result always coincides with the block falling idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// One request gives one strobe, never two in a row.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// The reported term index stays within the term limit.
	a_terms_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((terms_used != '0) &&
		          (terms_used <= cts_pkg::TERMS_W'(cts_pkg::MAX_TERMS))))
		else $error("terms_used out of range");

	// Hitting the cap means the term limit was reached.
	a_capped_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && capped) |-> (terms_used == cts_pkg::TERMS_W'(cts_pkg::MAX_TERMS)))
		else $error("capped without reaching the term limit");

endmodule

bind cosine_taylor_series cts_checker u_cts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.terms_used (terms_used),
	.capped     (capped)
);

/* test/testbench.sv */
// -----------------------------------------------------------------------------
// Cosine series testbench
// Drives angle requests in both modes through several register settings and
// checks every result against a bit-exact fixed-point predictor of the series.
// -----------------------------------------------------------------------------
module testbench;

	localparam logic [63:0] TERM_LIMIT = (64'd1 << 62) - 64'd1;
	localparam logic signed [63:0] SUM_LIMIT = 64'sd1 <<< 62;
	localparam logic signed [63:0] COS_HI = (64'sd1 <<< 57) - 64'sd1;
	localparam logic signed [63:0] COS_LO = -(64'sd1 <<< 57);
	localparam logic [63:0] REM_HI = (64'd1 << 57) - 64'd1;

	typedef struct {
		logic                               kind;
		logic signed [cts_pkg::ANGLE_W-1:0] angle;
	} request_t;

	typedef struct {
		logic [cts_pkg::COS_W-1:0]   cosine;
		logic [cts_pkg::REM_W-1:0]   remainder;
		logic [cts_pkg::TERMS_W-1:0] terms_used;
		logic                        capped;
	} series_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic kind;
	logic signed [cts_pkg::ANGLE_W-1:0] angle;
	logic done;
	logic signed [cts_pkg::COS_W-1:0] cosine;
	logic [cts_pkg::REM_W-1:0] remainder;
	logic [cts_pkg::TERMS_W-1:0] terms_used;
	logic capped;
	logic cfg_valid;
	logic cfg_ready;
	logic [cts_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cts_pkg::TOL_W-1:0] cfg_data;

	// Our own copy of the two registers, updated as each write is accepted.
	logic [cts_pkg::TOL_W-1:0] tol_copy;
	logic [cts_pkg::CNT_W-1:0] count_copy;

	request_t pending_requests[$];
	series_t  expected_sums[$];
	int error_count;
	int gap_left;
	bit took;
	bit no_gaps;

	cosine_taylor_series uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.angle      (angle),
		.done       (done),
		.cosine     (cosine),
		.remainder  (remainder),
		.terms_used (terms_used),
		.capped     (capped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// floor(a * b / 2^50), saturated at the largest term magnitude.
	function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		p = p >> cts_pkg::FRAC_W;
		if (p > 128'(TERM_LIMIT))
			return TERM_LIMIT;
		return p[63:0];
	endfunction

	// Magnitude of term k, given the magnitude of term k-1 and |x|.
	function automatic logic [63:0] next_term(logic [63:0] mag, logic [63:0] ax, int k);
		logic [63:0] d;
		d = 64'((2 * k) * (2 * k - 1));
		return scaled_product(scaled_product(mag, ax), ax) / d;
	endfunction

	function automatic logic signed [63:0] accumulate(logic signed [63:0] sum,
			logic [63:0] mag, bit neg);
		logic signed [63:0] s;
		s = neg ? sum - $signed(mag) : sum + $signed(mag);
		if (s > SUM_LIMIT)
			s = SUM_LIMIT;
		if (s < -SUM_LIMIT)
			s = -SUM_LIMIT;
		return s;
	endfunction

	// Works out the partial sum, the omitted term, its index and the cap flag.
	function automatic series_t cosine_series(request_t r);
		series_t res;
		logic [63:0] ax;
		logic [63:0] mag;
		logic [63:0] nm;
		logic [63:0] rem;
		logic signed [63:0] sum;
		bit neg;
		bit cap;
		int k;
		int n;
		ax = r.angle[cts_pkg::ANGLE_W-1] ? 64'(-65'(r.angle)) : 64'(r.angle);
		mag = 64'd1 << cts_pkg::FRAC_W;
		sum = $signed(mag);
		neg = 0;
		cap = 0;
		k = 1;
		rem = 0;
		if (r.kind == cts_pkg::KIND_TOL) begin
			// The first correction is always taken; the tolerance test starts at term 2.
			mag = next_term(mag, ax, 1);
			neg = 1;
			sum = accumulate(sum, mag, neg);
			k = 2;
			forever begin
				nm = next_term(mag, ax, k);
				neg = !neg;
				if (nm < 64'(tol_copy)) begin
					rem = nm;
					break;
				end
				if (k >= cts_pkg::MAX_TERMS) begin
					rem = nm;
					cap = 1;
					break;
				end
				sum = accumulate(sum, nm, neg);
				mag = nm;
				k++;
			end
		end else begin
			// A count of zero acts as one, and one above the limit as the limit.
			n = int'(count_copy);
			if (n < 1)
				n = 1;
			if (n > cts_pkg::MAX_TERMS)
				n = cts_pkg::MAX_TERMS;
			forever begin
				mag = next_term(mag, ax, k);
				neg = !neg;
				if (k >= n) begin
					rem = mag;
					break;
				end
				sum = accumulate(sum, mag, neg);
				k++;
			end
		end
		if (sum > COS_HI)
			sum = COS_HI;
		if (sum < COS_LO)
			sum = COS_LO;
		if (rem > REM_HI)
			rem = REM_HI;
		res.cosine = sum[cts_pkg::COS_W-1:0];
		res.remainder = rem[cts_pkg::REM_W-1:0];
		res.terms_used = k[cts_pkg::TERMS_W-1:0];
		res.capped = cap;
		return res;
	endfunction

	// Driver: a request stays on the ports until it is taken, then the next one
	// follows after a random pause, or at once when gaps are switched off.
	always @(negedge clk) begin
		request_t r;
		if (arst_n && !(start && !took)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				r = pending_requests.pop_front();
				kind <= r.kind;
				angle <= r.angle;
				start <= 1'b1;
				gap_left = no_gaps ? 0 : $urandom_range(0, 6);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predicts each request as it is taken and checks every strobe.
	always @(posedge clk) begin
		request_t r;
		series_t want;
		took = arst_n && start && !busy;
		if (took) begin
			r.kind = kind;
			r.angle = angle;
			expected_sums.push_back(cosine_series(r));
		end
		if (arst_n && done) begin
			if (expected_sums.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				want = expected_sums.pop_front();
				if (cosine !== want.cosine) begin
					$error("cosine: expected %0d, got %0d", $signed(want.cosine), cosine);
					error_count++;
				end
				if (remainder !== want.remainder) begin
					$error("remainder: expected %0d, got %0d", want.remainder, remainder);
					error_count++;
				end
				if (terms_used !== want.terms_used) begin
					$error("terms_used: expected %0d, got %0d", want.terms_used, terms_used);
					error_count++;
				end
				if (capped !== want.capped) begin
					$error("capped: expected %0d, got %0d", want.capped, capped);
					error_count++;
				end
			end
		end
	end

	// Registers are only written once the block has gone idle.
	task automatic write_register(logic [cts_pkg::CFG_IDX_W-1:0] idx,
			logic [cts_pkg::TOL_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == cts_pkg::CFG_TOL)
			tol_copy = value;
		else
			count_copy = value[cts_pkg::CNT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle;
		do
			@(posedge clk);
		while (pending_requests.size() > 0 || start || expected_sums.size() > 0);
	endtask

	task automatic queue_request(logic k, logic signed [cts_pkg::ANGLE_W-1:0] a);
		request_t r;
		r.kind = k;
		r.angle = a;
		pending_requests.push_back(r);
	endtask

	// Full-width random angles, most of them shifted down so that the bulk sit
	// in the reduced range where the series converges in a sensible number of terms.
	function automatic logic signed [cts_pkg::ANGLE_W-1:0] random_angle;
		logic signed [cts_pkg::ANGLE_W-1:0] a;
		a = cts_pkg::ANGLE_W'({$urandom, $urandom});
		if ($urandom_range(0, 3) != 0)
			a = a >>> $urandom_range(1, 12);
		return a;
	endfunction

	function automatic logic [cts_pkg::TOL_W-1:0] random_tolerance;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return cts_pkg::TOL_W'(64'd1 << cts_pkg::FRAC_W);
			2: return cts_pkg::TOL_W'($urandom_range(1, 1000));
			default: return cts_pkg::TOL_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
		endcase
	endfunction

	localparam logic signed [cts_pkg::ANGLE_W-1:0] ANGLE_TOP =
		{1'b0, {(cts_pkg::ANGLE_W-1){1'b1}}};
	localparam logic signed [cts_pkg::ANGLE_W-1:0] ANGLE_BOTTOM =
		{1'b1, {(cts_pkg::ANGLE_W-1){1'b0}}};
	localparam logic signed [cts_pkg::ANGLE_W-1:0] ANGLE_PI =
		cts_pkg::ANGLE_W'(64'd3537118876014220);
	localparam logic signed [cts_pkg::ANGLE_W-1:0] ANGLE_STEP = cts_pkg::ANGLE_W'(1);

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = cts_pkg::KIND_TOL;
		angle = '0;
		cfg_valid = 1'b0;
		cfg_index = cts_pkg::CFG_TOL;
		cfg_data = '0;
		tol_copy = cts_pkg::TOL_RESET;
		count_copy = cts_pkg::CNT_RESET;
		error_count = 0;
		gap_left = 0;
		took = 0;
		no_gaps = 0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests under the reset settings: zero, the angle extremes,
		// the smallest steps and values near pi, in both modes.
		queue_request(cts_pkg::KIND_TOL, '0);
		queue_request(cts_pkg::KIND_FIXED, '0);
		queue_request(cts_pkg::KIND_TOL, ANGLE_TOP);
		queue_request(cts_pkg::KIND_FIXED, ANGLE_BOTTOM);
		queue_request(cts_pkg::KIND_TOL, ANGLE_BOTTOM);
		queue_request(cts_pkg::KIND_TOL, ANGLE_STEP);
		queue_request(cts_pkg::KIND_FIXED, -ANGLE_STEP);
		queue_request(cts_pkg::KIND_TOL, ANGLE_PI);
		queue_request(cts_pkg::KIND_FIXED, -ANGLE_PI);
		wait_idle();

		// Zero tolerance forces the term limit; a count of zero acts as one.
		write_register(cts_pkg::CFG_TOL, '0);
		write_register(cts_pkg::CFG_CNT, '0);
		queue_request(cts_pkg::KIND_TOL, ANGLE_PI);
		queue_request(cts_pkg::KIND_TOL, '0);
		queue_request(cts_pkg::KIND_FIXED, ANGLE_PI);
		wait_idle();

		// A tolerance of one (2^50) and a count above the limit.
		write_register(cts_pkg::CFG_TOL, cts_pkg::TOL_W'(64'd1 << cts_pkg::FRAC_W));
		write_register(cts_pkg::CFG_CNT, cts_pkg::TOL_W'(63));
		queue_request(cts_pkg::KIND_TOL, ANGLE_TOP);
		queue_request(cts_pkg::KIND_TOL, ANGLE_STEP);
		queue_request(cts_pkg::KIND_FIXED, -ANGLE_PI);
		queue_request(cts_pkg::KIND_FIXED, ANGLE_TOP);
		wait_idle();

		write_register(cts_pkg::CFG_TOL, cts_pkg::TOL_W'(1));
		write_register(cts_pkg::CFG_CNT, cts_pkg::TOL_W'(cts_pkg::MAX_TERMS));
		queue_request(cts_pkg::KIND_TOL, ANGLE_PI);
		queue_request(cts_pkg::KIND_FIXED, ANGLE_BOTTOM);
		queue_request(cts_pkg::KIND_FIXED, ANGLE_STEP);
		wait_idle();

		// Random phases, each under fresh settings; every other phase runs
		// back to back so that requests also arrive without any pause.
		for (int phase = 0; phase < 9; phase++) begin
			write_register(cts_pkg::CFG_TOL, random_tolerance());
			write_register(cts_pkg::CFG_CNT, ($urandom_range(0, 3) == 0) ?
				cts_pkg::TOL_W'(cts_pkg::CNT_W'($urandom)) :
				cts_pkg::TOL_W'($urandom_range(1, 12)));
			no_gaps = (phase % 2) == 1;
			for (int i = 0; i < 81; i++)
				queue_request(logic'($urandom_range(0, 1)), random_angle());
			wait_idle();
		end

		repeat (200)
			@(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Far beyond the slowest correct run: every request at the term limit.
	initial begin
		#40000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
